[src/hpcc_pkg.sv]
// Shared types, constants and helper functions for the HSV pixel classifier.
`timescale 1ns / 1ps
`default_nettype none
package hpcc_pkg;

    localparam int PIX_W        = 8;
    localparam int HN_W         = 17;                 // 60 * hue numerator, up to 360*255
    localparam int HUE_W        = 14;
    localparam int HUE_Q_W      = 13;                 // hue quotient stays below 5760
    localparam int HUE_DVD_W    = HN_W + 4;           // 16 * hn
    localparam int SAT_DVD_W    = 2 * PIX_W;          // 255 * d
    localparam int FRONT_STAGES = 2;
    localparam int PIPE_STAGES  = FRONT_STAGES + HUE_Q_W;

    localparam logic signed [HUE_W-1:0] HUE_BLACK = -14'sd16;

    typedef enum logic [3:0] {
        CLASS_BLUE_ZOMBIE   = 4'd0,
        CLASS_AQUA_ZOMBIE   = 4'd1,
        CLASS_GREEN_ZOMBIE  = 4'd2,
        CLASS_PURPLE_ZOMBIE = 4'd3,
        CLASS_RED_BERRY     = 4'd4,
        CLASS_YELLOW_BERRY  = 4'd5,
        CLASS_ORANGE_BERRY  = 4'd6,
        CLASS_PINK_BERRY    = 4'd7,
        CLASS_STUMP         = 4'd8,
        CLASS_TREE          = 4'd9,
        CLASS_WALL          = 4'd10,
        CLASS_NONE          = 4'd11
    } t_class;

    typedef struct packed {
        logic hi;     // s >= 0.7
        logic le50;   // s <= 0.5
        logic le40;   // s <= 0.4
        logic lt40;   // s <  0.4
        logic le30;   // s <= 0.3
        logic v_lo;   // v <  0.15
    } t_sat;

    typedef struct packed {
        logic [HN_W-1:0]  hn;
        logic [PIX_W-1:0] d;
        logic [PIX_W-1:0] mx;
        logic             black;
        logic             grey;
        t_sat             sat;
    } t_front;

    typedef struct packed {
        logic green;
        logic purple;
        logic aqua;
        logic blue;
        logic pink;
        logic yellow;
        logic orange;
        logic red;
        logic wall;
        logic stump;
        logic tree;
    } t_win;

    typedef struct packed {
        t_class           cls;
        logic [PIX_W-1:0] mx;
        logic             black;
        logic             grey;
    } t_tail;

    // lo <= hn/d <= hi, whole degrees, by cross-multiplication
    function automatic logic in_win(input logic [HN_W-1:0] hn, input logic [PIX_W-1:0] d,
                                    input logic [HN_W-1:0] lo, input logic [HN_W-1:0] hi);
        logic [HN_W-1:0] lo_d;
        logic [HN_W-1:0] hi_d;
        lo_d = lo * HN_W'(d);
        hi_d = hi * HN_W'(d);
        return (hn >= lo_d) && (hn <= hi_d);
    endfunction

endpackage
`default_nettype wire

[src/hsv_pixel_color_classifier.sv]
// Top level of the HSV pixel classifier: stage control, front end, class chain, dividers.
//
//  channel | direction | handshake                  | beat payload
//  --------+-----------+----------------------------+-----------------------------------------
//  pixel   | in        | i_in_valid / o_in_ready    | i_red, i_green, i_blue
//  result  | out       | o_out_valid / i_out_ready  | o_object_class, o_hue_sixteenths,
//          |           |                            | o_saturation, o_brightness
//
// One beat enters per clock while the output is not stalled; two front stages (max/min, then
// hue numerator and saturation flags) lead into the 13-stage hue divider, one quotient bit
// per stage, which sets the depth. Class and saturation run alongside the divider.
// Each stage holds a valid bit and loads when it is empty or its successor loads,
// so a stalled output holds only the stages behind it and bubbles fill up.
// Reset (i_rst_n low at a clock edge) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
module hsv_pixel_color_classifier (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [hpcc_pkg::PIX_W-1:0]             i_red,
    input  wire logic [hpcc_pkg::PIX_W-1:0]             i_green,
    input  wire logic [hpcc_pkg::PIX_W-1:0]             i_blue,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic [3:0]                                  o_object_class,
    output logic signed [hpcc_pkg::HUE_W-1:0]           o_hue_sixteenths,
    output logic [hpcc_pkg::PIX_W-1:0]                  o_saturation,
    output logic [hpcc_pkg::PIX_W-1:0]                  o_brightness
);

    localparam int NS = hpcc_pkg::PIPE_STAGES;
    localparam int FS = hpcc_pkg::FRONT_STAGES;
    localparam int QW = hpcc_pkg::HUE_Q_W;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] c_ld;

    // a stage loads when empty or when the next one takes its beat
    assign c_ld[NS-1] = !r_vld[NS-1] || i_out_ready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_ld
        assign c_ld[k] = !r_vld[k] || c_ld[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (c_ld[0]) r_vld[0] <= i_in_valid;
            for (int k = 1; k < NS; k++) begin
                if (c_ld[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_in_ready  = c_ld[0];
    assign o_out_valid = r_vld[NS-1];

    hpcc_pkg::t_front                      front;
    logic [hpcc_pkg::SAT_DVD_W-1:0]        sat_dvd;
    hpcc_pkg::t_tail                       tail;
    logic [QW-1:0]                         q_hue;
    logic [QW-1:0]                         q_sat;

    hpcc_front u_front (
        .i_clk     (i_clk),
        .i_ld      (c_ld[FS-1:0]),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .o_front   (front),
        .o_sat_dvd (sat_dvd)
    );

    hpcc_class #(.DEPTH(QW)) u_class (
        .i_clk   (i_clk),
        .i_ld    (c_ld[NS-1:FS]),
        .i_front (front),
        .o_tail  (tail)
    );

    hpcc_div #(
        .DVD_W (hpcc_pkg::HUE_DVD_W),
        .DVS_W (hpcc_pkg::PIX_W),
        .Q_W   (QW)
    ) u_div_hue (
        .i_clk      (i_clk),
        .i_ld       (c_ld[NS-1:FS]),
        .i_dividend ({front.hn, 4'b0000}),
        .i_divisor  (front.d),
        .o_quotient (q_hue)
    );

    // same depth as the hue divider; the top quotient bits come out zero
    hpcc_div #(
        .DVD_W (hpcc_pkg::SAT_DVD_W),
        .DVS_W (hpcc_pkg::PIX_W),
        .Q_W   (QW)
    ) u_div_sat (
        .i_clk      (i_clk),
        .i_ld       (c_ld[NS-1:FS]),
        .i_dividend (sat_dvd),
        .i_divisor  (front.mx),
        .o_quotient (q_sat)
    );

    // black divides by zero and grey has no hue: drop the quotients there
    assign o_object_class   = tail.cls;
    assign o_brightness     = tail.mx;
    assign o_hue_sixteenths = tail.black ? hpcc_pkg::HUE_BLACK
                            : (tail.grey ? '0 : $signed({1'b0, q_hue}));
    assign o_saturation     = (tail.black || tail.grey) ? '0 : q_sat[hpcc_pkg::PIX_W-1:0];

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_object_class <= hpcc_pkg::CLASS_NONE)
        else $error("class code out of range");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_brightness == '0 |->
            o_object_class == hpcc_pkg::CLASS_TREE && o_hue_sixteenths == hpcc_pkg::HUE_BLACK)
        else $error("black pixel misclassified");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_brightness != '0 |->
            o_hue_sixteenths >= 14'sd0 && o_hue_sixteenths < 14'sd5760)
        else $error("hue out of range");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while pipeline drains freely");

endmodule
`default_nettype wire

[src/hpcc_front.sv]
// Front stages: max/min/delta, then hue numerator and saturation flags.
`timescale 1ns / 1ps
`default_nettype none
module hpcc_front (
    input  wire logic                               i_clk,
    input  wire logic [1:0]                         i_ld,
    input  wire logic [hpcc_pkg::PIX_W-1:0]         i_red,
    input  wire logic [hpcc_pkg::PIX_W-1:0]         i_green,
    input  wire logic [hpcc_pkg::PIX_W-1:0]         i_blue,
    output hpcc_pkg::t_front                        o_front,
    output logic [hpcc_pkg::SAT_DVD_W-1:0]          o_sat_dvd
);

    typedef enum logic [2:0] {
        SECT_RED   = 3'b001,
        SECT_GREEN = 3'b010,
        SECT_BLUE  = 3'b100
    } t_sect;

    // stage 0
    logic [hpcc_pkg::PIX_W-1:0] n_mx, n_mn, r_mx, r_d;
    logic signed [9:0]          n_diff, r_diff;
    t_sect                      n_sect, r_sect;

    always_comb begin
        n_mx = i_red;
        n_mn = i_red;
        if (i_green > n_mx) n_mx = i_green;
        if (i_blue  > n_mx) n_mx = i_blue;
        if (i_green < n_mn) n_mn = i_green;
        if (i_blue  < n_mn) n_mn = i_blue;
        priority if (i_red == n_mx) begin
            n_sect = SECT_RED;
            n_diff = $signed({2'b00, i_green}) - $signed({2'b00, i_blue});
        end else if (i_green == n_mx) begin
            n_sect = SECT_GREEN;
            n_diff = $signed({2'b00, i_blue}) - $signed({2'b00, i_red});
        end else begin
            n_sect = SECT_BLUE;
            n_diff = $signed({2'b00, i_red}) - $signed({2'b00, i_green});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_mx   <= n_mx;
            r_d    <= n_mx - n_mn;
            r_diff <= n_diff;
            r_sect <= n_sect;
        end
    end

    // stage 1
    logic signed [11:0] c_base, c_t, c_tw;
    logic [12:0]        c_d13, c_m13;
    hpcc_pkg::t_front   n_front;

    always_comb begin
        unique case (r_sect)
            SECT_RED:   c_base = '0;
            SECT_GREEN: c_base = $signed({3'b000, r_d, 1'b0});
            SECT_BLUE:  c_base = $signed({2'b00, r_d, 2'b00});
            default:    c_base = '0;
        endcase
        c_t  = c_base + 12'(r_diff);
        // wrap negative hue by adding 360 degrees
        c_tw = c_t[11] ? (c_t + $signed(12'(r_d) * 12'd6)) : c_t;
        c_d13 = 13'(r_d);
        c_m13 = 13'(r_mx);
        n_front.hn       = {6'b0, c_tw[10:0]} * 17'd60;
        n_front.d        = r_d;
        n_front.mx       = r_mx;
        n_front.black    = (r_mx == '0);
        n_front.grey     = (r_d == '0) && (r_mx != '0);
        n_front.sat.hi   = (c_d13 * 13'd10) >= (c_m13 * 13'd7);
        n_front.sat.le50 = (c_d13 * 13'd2)  <= c_m13;
        n_front.sat.le40 = (c_d13 * 13'd5)  <= (c_m13 * 13'd2);
        n_front.sat.lt40 = (c_d13 * 13'd5)  <  (c_m13 * 13'd2);
        n_front.sat.le30 = (c_d13 * 13'd10) <= (c_m13 * 13'd3);
        n_front.sat.v_lo = (c_m13 * 13'd20) <  13'd765;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            o_front   <= n_front;
            o_sat_dvd <= hpcc_pkg::SAT_DVD_W'(r_d) * 16'd255;
        end
    end

endmodule
`default_nettype wire

[src/hpcc_class.sv]
// Class stages: hue window compares, priority chain, then delay to match the dividers.
`timescale 1ns / 1ps
`default_nettype none
module hpcc_class #(
    parameter int DEPTH = hpcc_pkg::HUE_Q_W
) (
    input  wire logic               i_clk,
    input  wire logic [DEPTH-1:0]   i_ld,
    input  wire hpcc_pkg::t_front   i_front,
    output hpcc_pkg::t_tail         o_tail
);

    hpcc_pkg::t_win n_win, r_win;
    hpcc_pkg::t_sat r_sat;
    logic [hpcc_pkg::PIX_W-1:0] r_mx;
    logic r_black, r_grey;

    always_comb begin
        n_win.green  = hpcc_pkg::in_win(i_front.hn, i_front.d, 17'd120, 17'd132);
        n_win.purple = hpcc_pkg::in_win(i_front.hn, i_front.d, 17'd250, 17'd280);
        n_win.aqua   = hpcc_pkg::in_win(i_front.hn, i_front.d, 17'd165, 17'd185);
        n_win.blue   = hpcc_pkg::in_win(i_front.hn, i_front.d, 17'd200, 17'd225);
        n_win.pink   = hpcc_pkg::in_win(i_front.hn, i_front.d, 17'd315, 17'd340);
        n_win.yellow = hpcc_pkg::in_win(i_front.hn, i_front.d, 17'd40,  17'd60);
        n_win.orange = hpcc_pkg::in_win(i_front.hn, i_front.d, 17'd15,  17'd35);
        n_win.red    = hpcc_pkg::in_win(i_front.hn, i_front.d, 17'd0,   17'd10);
        n_win.wall   = hpcc_pkg::in_win(i_front.hn, i_front.d, 17'd220, 17'd230);
        n_win.stump  = hpcc_pkg::in_win(i_front.hn, i_front.d, 17'd210, 17'd230);
        n_win.tree   = (i_front.hn >= 17'd220 * 17'(i_front.d))
                    || (i_front.hn <  17'd30  * 17'(i_front.d));
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_win   <= n_win;
            r_sat   <= i_front.sat;
            r_mx    <= i_front.mx;
            r_black <= i_front.black;
            r_grey  <= i_front.grey;
        end
    end

    hpcc_pkg::t_class c_win_cls;
    hpcc_pkg::t_class n_cls;

    always_comb begin
        priority if (r_win.green && r_sat.hi)   c_win_cls = hpcc_pkg::CLASS_GREEN_ZOMBIE;
        else if (r_win.purple && r_sat.hi)      c_win_cls = hpcc_pkg::CLASS_PURPLE_ZOMBIE;
        else if (r_win.aqua && r_sat.hi)        c_win_cls = hpcc_pkg::CLASS_AQUA_ZOMBIE;
        else if (r_win.blue && r_sat.hi)        c_win_cls = hpcc_pkg::CLASS_BLUE_ZOMBIE;
        else if (r_win.pink && r_sat.le50)      c_win_cls = hpcc_pkg::CLASS_PINK_BERRY;
        else if (r_win.yellow && r_sat.hi)      c_win_cls = hpcc_pkg::CLASS_YELLOW_BERRY;
        else if (r_win.orange)                  c_win_cls = hpcc_pkg::CLASS_ORANGE_BERRY;
        else if (r_win.red && r_sat.hi)         c_win_cls = hpcc_pkg::CLASS_RED_BERRY;
        else                                    c_win_cls = hpcc_pkg::CLASS_NONE;
        // black and grey have no real hue: every window test is moot
        priority if (r_black)
            n_cls = hpcc_pkg::CLASS_TREE;
        else if (r_grey)
            n_cls = hpcc_pkg::CLASS_NONE;
        // overrides replace the window result
        else if (r_win.wall && r_sat.le40)
            n_cls = hpcc_pkg::CLASS_WALL;
        else if (r_win.stump && r_sat.le30 && r_sat.v_lo)
            n_cls = hpcc_pkg::CLASS_STUMP;
        else if (r_win.tree && r_sat.lt40 && r_sat.v_lo)
            n_cls = hpcc_pkg::CLASS_TREE;
        else
            n_cls = c_win_cls;
    end

    hpcc_pkg::t_tail r_tail [1:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r_tail[1].cls   <= n_cls;
            r_tail[1].mx    <= r_mx;
            r_tail[1].black <= r_black;
            r_tail[1].grey  <= r_grey;
        end
    end

    for (genvar k = 2; k < DEPTH; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (i_ld[k]) r_tail[k] <= r_tail[k-1];
        end
    end

    assign o_tail = r_tail[DEPTH-1];

endmodule
`default_nettype wire

[src/hpcc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module hpcc_div #(
    parameter int DVD_W = hpcc_pkg::HUE_DVD_W,
    parameter int DVS_W = hpcc_pkg::PIX_W,
    parameter int Q_W   = hpcc_pkg::HUE_Q_W
) (
    input  wire logic               i_clk,
    input  wire logic [Q_W-1:0]     i_ld,
    input  wire logic [DVD_W-1:0]   i_dividend,
    input  wire logic [DVS_W-1:0]   i_divisor,
    output logic [Q_W-1:0]          o_quotient
);

    logic [DVD_W-1:0] c_hi;
    logic [DVS_W-1:0] c_rem [Q_W];
    logic [Q_W-1:0]   c_lo  [Q_W];
    logic [Q_W-1:0]   c_q   [Q_W];
    logic [DVS_W-1:0] c_dvs [Q_W];
    logic [DVS_W:0]   c_trial [Q_W];
    logic             c_ge  [Q_W];

    logic [DVS_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0]   r_lo  [Q_W];
    logic [Q_W-1:0]   r_q   [Q_W];
    logic [DVS_W-1:0] r_dvs [Q_W];

    // upper dividend bits are known to stay below the divisor
    assign c_hi     = i_dividend >> Q_W;
    assign c_rem[0] = c_hi[DVS_W-1:0];
    assign c_lo[0]  = i_dividend[Q_W-1:0];
    assign c_q[0]   = '0;
    assign c_dvs[0] = i_divisor;

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        if (k > 0) begin : g_link
            assign c_rem[k] = r_rem[k-1];
            assign c_lo[k]  = r_lo[k-1];
            assign c_q[k]   = r_q[k-1];
            assign c_dvs[k] = r_dvs[k-1];
        end
        assign c_trial[k] = {c_rem[k], c_lo[k][Q_W-1]};
        assign c_ge[k]    = c_trial[k] >= {1'b0, c_dvs[k]};

        always_ff @(posedge i_clk) begin
            if (i_ld[k]) begin
                r_rem[k] <= c_ge[k] ? DVS_W'(c_trial[k] - {1'b0, c_dvs[k]})
                                    : c_trial[k][DVS_W-1:0];
                r_lo[k]  <= c_lo[k] << 1;
                r_q[k]   <= {c_q[k][Q_W-2:0], c_ge[k]};
                r_dvs[k] <= c_dvs[k];
            end
        end
    end

    assign o_quotient = r_q[Q_W-1];

endmodule
`default_nettype wire
